### rtl/nirt_pkg.sv
// Package for the NEC infrared frame transmitter.
// Holds the shared word types, register indexes, reset values and the byte serializer.
// Depends on nothing; every other file of the block imports it.
package nirt_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_CHECK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BURST   = 3'd4;

    // Reset values
    localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
    localparam logic [11:0] RST_UNIT_TICKS   = 12'd560;

    // Operation codes of an input word
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    typedef struct packed {
        logic [7:0]  carrier_half_ticks;
        logic [11:0] unit_ticks;
        logic        lsb_first;
        logic        invert_check;
        logic        stop_burst_enable;
    } t_cfg;

    typedef struct packed {
        logic       operation;
        logic [7:0] address_first;
        logic [7:0] address_second;
        logic [7:0] command;
    } t_in_word;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_out_word;

    // Place each byte so that bit 0 of the result goes out first
    function automatic logic [7:0] ser_byte(input logic [7:0] b, input logic lsb_first);
        logic [7:0] r;
        for (int j = 0; j < 8; j++) begin
            r[j] = lsb_first ? b[j] : b[7-j];
        end
        return r;
    endfunction

endpackage

### rtl/nirt_in_if.sv
// Input channel of the NEC infrared frame transmitter: valid/ready plus the input word.
// Depends on nirt_pkg for the payload type.
interface nirt_in_if import nirt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] address_first;
    logic [7:0] address_second;
    logic [7:0] command;

    modport source (output valid, output operation, output address_first,
                    output address_second, output command, input ready);
    modport sink   (input valid, input operation, input address_first,
                    input address_second, input command, output ready);
endinterface

### rtl/nirt_out_if.sv
// Output channel of the NEC infrared frame transmitter: valid/ready plus the result word.
// Depends on nirt_pkg for the payload type.
interface nirt_out_if import nirt_pkg::*; ();
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;

    modport source (output valid, output line_level, output busy_res,
                    output frame_done, output rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input frame_done, input rejected, output ready);
endinterface

### rtl/nirt_cfg_regs.sv
// Configuration register file of the NEC infrared frame transmitter.
// Decodes the plain write port into the t_cfg struct; depends on nirt_pkg.
module nirt_cfg_regs import nirt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CARRIER_HALF: n_cfg.carrier_half_ticks = i_cfg_data[7:0];
                REG_UNIT_TICKS:   n_cfg.unit_ticks         = i_cfg_data[11:0];
                REG_LSB_FIRST:    n_cfg.lsb_first          = i_cfg_data[0];
                REG_INVERT_CHECK: n_cfg.invert_check       = i_cfg_data[0];
                REG_STOP_BURST:   n_cfg.stop_burst_enable  = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_half_ticks <= RST_CARRIER_HALF;
            r_cfg.unit_ticks         <= RST_UNIT_TICKS;
            r_cfg.lsb_first          <= 1'b1;
            r_cfg.invert_check       <= 1'b1;
            r_cfg.stop_burst_enable  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/nirt_core.sv
// Frame sequencer of the NEC infrared frame transmitter: phase, timing and carrier counters.
// Advances one step per accepted word and produces its result word; depends on nirt_pkg.
module nirt_core import nirt_pkg::*; #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_step,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    localparam int unsigned BIT_CNT_W = $clog2(FRAME_BITS + 1);
    localparam int unsigned BIT_IDX_W = $clog2(FRAME_BITS);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_LEAD_BURST = 3'd1;
    localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
    localparam logic [2:0] PH_BIT_BURST  = 3'd3;
    localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
    localparam logic [2:0] PH_STOP_BURST = 3'd5;

    logic [2:0]            r_phase,     n_phase;
    logic [FRAME_BITS-1:0] r_frame,     n_frame;
    logic [BIT_CNT_W-1:0]  r_bit_idx,   n_bit_idx;
    logic [15:0]           r_ticks,     n_ticks;
    logic [7:0]            r_carrier,   n_carrier;
    logic                  r_line,      n_line;

    logic [11:0] unit;
    logic [7:0]  half;
    logic [15:0] len;
    logic [15:0] ticks_inc;
    logic [7:0]  carrier_inc;
    logic [BIT_CNT_W-1:0] bit_inc;
    logic        cur_bit;
    logic        in_burst;
    logic [7:0]  check_byte;
    logic [31:0] frame_word;
    logic        done;
    logic        rej;

    assign unit = (i_cfg.unit_ticks == 12'd0) ? 12'd1 : i_cfg.unit_ticks;
    assign half = (i_cfg.carrier_half_ticks == 8'd0) ? 8'd1 : i_cfg.carrier_half_ticks;
    assign cur_bit = r_frame[r_bit_idx[BIT_IDX_W-1:0]];
    assign in_burst = (r_phase == PH_LEAD_BURST) || (r_phase == PH_BIT_BURST) ||
                      (r_phase == PH_STOP_BURST);

    // Phase length in ticks: 16, 8, 3 or 1 units
    always_comb begin
        unique case (r_phase)
            PH_LEAD_BURST: len = {unit, 4'b0000};
            PH_LEAD_SPACE: len = {1'b0, unit, 3'b000};
            PH_BIT_SPACE:  len = cur_bit ? ({4'b0000, unit} + {3'b000, unit, 1'b0})
                                         : {4'b0000, unit};
            default:       len = {4'b0000, unit};
        endcase
    end

    assign check_byte = i_cfg.invert_check ? ~i_word.command : i_word.command;
    assign frame_word = {ser_byte(check_byte, i_cfg.lsb_first),
                         ser_byte(i_word.command, i_cfg.lsb_first),
                         ser_byte(i_word.address_second, i_cfg.lsb_first),
                         ser_byte(i_word.address_first, i_cfg.lsb_first)};

    assign ticks_inc   = r_ticks + 16'd1;
    assign carrier_inc = r_carrier + 8'd1;
    assign bit_inc     = r_bit_idx + BIT_CNT_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_frame   = r_frame;
        n_bit_idx = r_bit_idx;
        n_ticks   = r_ticks;
        n_carrier = r_carrier;
        n_line    = r_line;
        done      = 1'b0;
        rej       = 1'b0;
        if (i_step) begin
            if (i_word.operation == OP_SEND) begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_frame   = frame_word[FRAME_BITS-1:0];
                    n_bit_idx = '0;
                    n_phase   = PH_LEAD_BURST;
                    n_ticks   = '0;
                    n_carrier = '0;
                    n_line    = 1'b0;
                end
            end else if (r_phase != PH_IDLE) begin
                if (ticks_inc >= len) begin
                    // Phase over: enter the next one with fresh counters
                    n_ticks   = '0;
                    n_carrier = '0;
                    unique case (r_phase)
                        PH_LEAD_BURST: begin
                            n_phase = PH_LEAD_SPACE;
                            n_line  = 1'b1;
                        end
                        PH_LEAD_SPACE: begin
                            n_phase = PH_BIT_BURST;
                            n_line  = 1'b0;
                        end
                        PH_BIT_BURST: begin
                            n_phase = PH_BIT_SPACE;
                            n_line  = 1'b1;
                        end
                        PH_BIT_SPACE: begin
                            n_bit_idx = bit_inc;
                            if (bit_inc < BIT_CNT_W'(FRAME_BITS)) begin
                                n_phase = PH_BIT_BURST;
                                n_line  = 1'b0;
                            end else if (i_cfg.stop_burst_enable) begin
                                n_phase = PH_STOP_BURST;
                                n_line  = 1'b0;
                            end else begin
                                n_phase = PH_IDLE;
                                n_line  = 1'b1;
                                done    = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_line  = 1'b1;
                            done    = 1'b1;
                        end
                    endcase
                end else begin
                    n_ticks = ticks_inc;
                    if (in_burst) begin
                        if (carrier_inc >= half) begin
                            n_line    = ~r_line;
                            n_carrier = '0;
                        end else begin
                            n_carrier = carrier_inc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_frame   <= '0;
            r_bit_idx <= '0;
            r_ticks   <= '0;
            r_carrier <= '0;
            r_line    <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_frame   <= n_frame;
            r_bit_idx <= n_bit_idx;
            r_ticks   <= n_ticks;
            r_carrier <= n_carrier;
            r_line    <= n_line;
        end
    end

    assign o_result.line_level = n_line;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.frame_done = done;
    assign o_result.rejected   = rej;

endmodule

### rtl/nirt_out_buf.sv
// Result register with a skid stage for the NEC infrared frame transmitter.
// Holds up to two result words so the input side keeps flowing; depends on nirt_pkg.
module nirt_out_buf import nirt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_can_push,
    output logic      o_valid,
    input  logic      i_pop_ready,
    output t_out_word o_word
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_word r_out_word;
    t_out_word r_skid_word;
    logic      pop;

    assign pop        = r_out_valid && i_pop_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_word     = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_word <= r_skid_word;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_word <= i_word;
            end else begin
                r_out_word <= i_word;
            end
        end
    end

endmodule

### rtl/nec_ir_frame_transmitter.sv
// Top level of the NEC infrared frame transmitter: config registers, frame sequencer
// and result buffer. Depends on nirt_pkg, nirt_in_if, nirt_out_if and the nirt_* modules.
//
//  channel   direction  handshake            word
//  i_in      in         valid/ready          operation, address_first, address_second, command
//  o_out     out        valid/ready          line_level, busy_res, frame_done, rejected
//  i_cfg_*   in         write enable only    index (3 bits), data (12 bits)
//
// One word per cycle while a result slot is free: each accepted tick or send updates the
// sequencer state in the cycle it is accepted and its result word is registered for the output side.
// Input ready drops only while both result slots (output register and skid) are full.
// Reset is synchronous, active low: line idle high, sequencer idle, registers at defaults.
module nec_ir_frame_transmitter import nirt_pkg::*; #(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nirt_in_if.sink               i_in,
    nirt_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_in_word  in_word;
    t_out_word result;
    t_out_word out_word;
    logic      can_push;
    logic      step;

    // Live configuration; timing fields are read every tick
    nirt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign in_word.operation      = i_in.operation;
    assign in_word.address_first  = i_in.address_first;
    assign in_word.address_second = i_in.address_second;
    assign in_word.command        = i_in.command;

    // Accept a word whenever a result slot is free
    assign i_in.ready = can_push;
    assign step       = i_in.valid && can_push;

    nirt_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_word   (in_word),
        .o_result (result)
    );

    // Hold results until the sink takes them
    nirt_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_word      (result),
        .o_can_push  (can_push),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_word      (out_word)
    );

    assign o_out.line_level = out_word.line_level;
    assign o_out.busy_res   = out_word.busy_res;
    assign o_out.frame_done = out_word.frame_done;
    assign o_out.rejected   = out_word.rejected;

endmodule
